[hdl/negacyclic_poly_mul_mod_q_assert.svh]
// Assertion macros for the negacyclic multiplier.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH
`define NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH

// Condition in this cycle implies consequence in this cycle.
`define NMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define NMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/nmq_pkg.sv]
// ----------------------------------------------------------------------------
// nmq_pkg
// Shared constants, types and codes of the negacyclic multiplier mod 12289.
// ----------------------------------------------------------------------------
package nmq_pkg;

  // Ring degree and coefficient store addressing.
  localparam int RING_DEGREE = 512;
  localparam int AW          = $clog2(RING_DEGREE);

  // Field widths.
  localparam int CW  = 14;
  localparam int IW  = 9;
  localparam int BW  = 13;
  localparam int PW  = 2 * CW;

  // Modulus and Barrett reduction constants.
  localparam logic [CW-1:0] Q_MOD  = 14'd12289;
  localparam int            BAR_K  = 42;
  localparam int            MW     = 29;
  localparam logic [MW-1:0] BAR_M  = MW'((64'd1 << BAR_K) / 64'(Q_MOD));

  // Command codes.
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_READ   = 2'd3
  } nmq_cmd_t;

  // Control shared by all cells of the accumulator ring.
  typedef struct packed {
    logic clr;
    logic shift;
  } nmq_cell_ctrl_t;

endpackage

[hdl/negacyclic_poly_mul_mod_q.sv]
// ----------------------------------------------------------------------------
// negacyclic_poly_mul_mod_q
// Schoolbook multiplier in Z_q[X]/(X^N+1), q = 12289, over a ring of cells.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (valid/stall) and each item gives one
// result item on the out_ channel. Load commands store an operand coefficient
// (reduced to a residue on the way in), a read command returns one product
// coefficient, and a run command forms the whole product.
// For loads and reads the result is presented the cycle after the item is
// taken, and a new item is taken every cycle while the receiver keeps taking
// results. While out_stall holds a result, the result register keeps it and
// in_stall is raised.
// A run is acknowledged at once, then occupies the block: one
// multiply-accumulate per cycle through a single pipelined multiplier and
// Barrett reducer, with the accumulators rotating through a ring of N cells,
// then a pass that copies the ring into the product memory. in_stall stays
// high meanwhile.
// After reset the product reads as zero until the first run completes;
// operand memories hold nothing defined until loaded.
module negacyclic_poly_mul_mod_q (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [nmq_pkg::IW-1:0]   in_index,
  input  logic [nmq_pkg::CW-1:0]   in_coef_a,
  input  logic signed [nmq_pkg::BW-1:0] in_coef_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [nmq_pkg::CW-1:0]   out_product_coef,
  output logic                     out_is_read_data
);
  import nmq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic            in_acc;
  logic            in_range;
  logic [AW-1:0]   in_addr;
  logic [CW-1:0]   a_red;
  logic [BW+1:0]   b_ext;
  logic [CW-1:0]   b_red;

  logic [CW-1:0]   a_mem [RING_DEGREE];
  logic [CW-1:0]   b_mem [RING_DEGREE];
  logic [CW-1:0]   p_mem [RING_DEGREE];

  logic [AW-1:0]   ci_r;
  logic [AW:0]     cj_r;
  logic            bubble;
  logic            last_issue;
  logic            issue;
  logic [CW-1:0]   a_rd_r;
  logic [CW-1:0]   b_rd_r;
  logic            v1_r;
  logic            sub1_r;
  logic            bub1_r;

  logic            mac_vld;
  logic            mac_sub;
  logic [CW-1:0]   mac_term;
  logic            mac_busy;

  logic [AW-1:0]   sw_k_r;
  logic            sweep_last;
  logic            done_r;

  logic [CW-1:0]   ring_q [RING_DEGREE];
  logic [CW-1:0]   head;
  logic [CW:0]     sum;
  logic [CW-1:0]   tail_d;
  nmq_cell_ctrl_t  cell_ctrl;

  logic            out_valid_r;
  logic            out_is_read_r;
  logic            out_sel_r;
  logic [CW-1:0]   rd_data_r;

  // Input handshake and operand conditioning.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = 32'(in_index) < RING_DEGREE;
  assign in_addr  = AW'(in_index);
  assign a_red    = (in_coef_a >= Q_MOD) ? (in_coef_a - Q_MOD) : in_coef_a;
  assign b_ext    = (BW + 2)'(in_coef_b) + (BW + 2)'(Q_MOD);
  assign b_red    = in_coef_b[BW-1] ? b_ext[CW-1:0] : CW'(in_coef_b);

  // Operand memories: written by loads, read at the issue counters.
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_LOAD_A && in_range) begin
      a_mem[in_addr] <= a_red;
    end
    a_rd_r <= a_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_LOAD_B && in_range) begin
      b_mem[in_addr] <= b_red;
    end
    b_rd_r <= b_mem[AW'(cj_r)];
  end

  // Issue sequencing: j runs one past the last term to realign the ring.
  assign bubble     = cj_r == (AW + 1)'(RING_DEGREE);
  assign last_issue = bubble && ci_r == AW'(RING_DEGREE - 1);
  assign issue      = state_r == ST_RUN;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      ci_r <= '0;
      cj_r <= '0;
    end else if (issue) begin
      if (bubble) begin
        cj_r <= '0;
        ci_r <= ci_r + 1'b1;
      end else begin
        cj_r <= cj_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    sub1_r <= ({1'b0, ci_r} + cj_r) >= (AW + 1)'(RING_DEGREE);
    bub1_r <= bubble;
  end

  nmq_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_sub   (sub1_r),
    .in_a     (a_rd_r),
    .in_b     (bub1_r ? '0 : b_rd_r),
    .out_vld  (mac_vld),
    .out_sub  (mac_sub),
    .out_term (mac_term),
    .busy     (mac_busy)
  );

  // Accumulate into the head cell; the result enters at the tail.
  assign head = ring_q[0];
  assign sum  = mac_sub ? ({1'b0, head} + {1'b0, Q_MOD} - {1'b0, mac_term})
                        : ({1'b0, head} + {1'b0, mac_term});

  always_comb begin
    if (state_r == ST_SWEEP) begin
      tail_d = head;
    end else if (sum >= {1'b0, Q_MOD}) begin
      tail_d = CW'(sum - {1'b0, Q_MOD});
    end else begin
      tail_d = sum[CW-1:0];
    end
  end

  assign cell_ctrl.clr   = in_acc && in_cmd == CMD_RUN;
  assign cell_ctrl.shift = (state_r == ST_SWEEP) || mac_vld;

  // The ring of accumulator cells.
  for (genvar k = 0; k < RING_DEGREE; k++) begin : g_ring
    nmq_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .d_in  ((k == RING_DEGREE - 1) ? tail_d : ring_q[(k + 1) % RING_DEGREE]),
      .q_out (ring_q[k])
    );
  end

  // Copy pass and read port of the product memory.
  assign sweep_last = sw_k_r == AW'(RING_DEGREE - 1);

  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP) begin
      p_mem[sw_k_r] <= head;
    end
    if (in_acc) begin
      rd_data_r <= p_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP) begin
      sw_k_r <= sw_k_r + 1'b1;
    end else begin
      sw_k_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (state_r == ST_SWEEP && sweep_last) begin
      done_r <= 1'b1;
    end
  end

  // Run sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_RUN) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !mac_busy) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_is_read_r <= in_cmd == CMD_READ;
      out_sel_r     <= in_cmd == CMD_READ && in_range && done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_read_data = out_is_read_r;
  assign out_product_coef = out_sel_r ? rd_data_r : '0;

  // Checks on the run sequencing.
  `include "negacyclic_poly_mul_mod_q_assert.svh"

  `NMQ_ASSERT_NEXT(a_run_starts, in_acc && in_cmd == CMD_RUN, state_r == ST_RUN, "run did not start")
  `NMQ_ASSERT_NOW(a_mac_in_run, mac_vld, state_r == ST_RUN || state_r == ST_DRAIN, "stray term")
  `NMQ_ASSERT_NEXT(a_sweep_ends, state_r == ST_SWEEP && sweep_last, state_r == ST_IDLE && done_r, "sweep end")

endmodule

[hdl/nmq_cell.sv]
// ----------------------------------------------------------------------------
// nmq_cell
// One accumulator cell of the ring; holds one product coefficient.
// ----------------------------------------------------------------------------
module nmq_cell (
  input  logic                       clk,
  input  nmq_pkg::nmq_cell_ctrl_t    ctrl,
  input  logic [nmq_pkg::CW-1:0]     d_in,
  output logic [nmq_pkg::CW-1:0]     q_out
);
  import nmq_pkg::*;

  logic [CW-1:0] val_r;

  // Clear at run start, otherwise take the neighbor's value on a shift.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      val_r <= '0;
    end else if (ctrl.shift) begin
      val_r <= d_in;
    end
  end

  assign q_out = val_r;

endmodule

[hdl/nmq_mac.sv]
// ----------------------------------------------------------------------------
// nmq_mac
// Pipelined product of two residues followed by Barrett reduction mod q.
// ----------------------------------------------------------------------------
module nmq_mac (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic                   in_sub,
  input  logic [nmq_pkg::CW-1:0] in_a,
  input  logic [nmq_pkg::CW-1:0] in_b,
  output logic                   out_vld,
  output logic                   out_sub,
  output logic [nmq_pkg::CW-1:0] out_term,
  output logic                   busy
);
  import nmq_pkg::*;

  localparam int TW = PW + MW;

  logic [3:0]      vld_r;
  logic [3:0]      sub_r;
  logic [PW-1:0]   p2_r;
  logic [PW-1:0]   p3_r;
  logic [TW-1:0]   t3_r;
  logic [PW-1:0]   p4_r;
  logic [PW-1:0]   qq4_r;
  logic [CW-1:0]   term5_r;
  logic [CW:0]     qhat;
  logic [PW-1:0]   diff;
  logic [CW:0]     rem;

  // Valid and sign flags travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    sub_r <= {sub_r[2:0], in_sub};
  end

  // Quotient estimate and remainder, which is below 2q.
  assign qhat = t3_r[TW-1 -: (CW + 1)];
  assign diff = p4_r - qq4_r;
  assign rem  = diff[CW:0];

  // Product, Barrett multiply, quotient times q, final correction.
  always_ff @(posedge clk) begin
    p2_r    <= in_a * in_b;
    t3_r    <= TW'(p2_r) * TW'(BAR_M);
    p3_r    <= p2_r;
    qq4_r   <= PW'(qhat) * PW'(Q_MOD);
    p4_r    <= p3_r;
    term5_r <= (rem >= {1'b0, Q_MOD}) ? CW'(rem - {1'b0, Q_MOD}) : rem[CW-1:0];
  end

  assign out_vld  = vld_r[3];
  assign out_sub  = sub_r[3];
  assign out_term = term5_r;
  assign busy     = |vld_r;

endmodule

[tb/nmq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmq_checker
// Watches both channels of the negacyclic multiplier. It keeps its own copy
// of the operand and product stores, works out the result of every accepted
// item, and compares each result item with the oldest one still waiting.
// ----------------------------------------------------------------------------
module nmq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [nmq_pkg::IW-1:0]        in_index,
  input  logic [nmq_pkg::CW-1:0]        in_coef_a,
  input  logic signed [nmq_pkg::BW-1:0] in_coef_b,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [nmq_pkg::CW-1:0]        out_product_coef,
  input  logic                          out_is_read_data,
  output int                            err_count,
  output int                            pending,
  output int                            reads_checked
);
  import nmq_pkg::*;

  localparam longint MODQ = 12289;

  typedef struct {
    logic [CW-1:0] coef;
    logic          is_read;
  } nmq_result_t;

  logic [CW-1:0]        opnd_a [RING_DEGREE];
  logic signed [BW-1:0] opnd_b [RING_DEGREE];
  logic [CW-1:0]        product [RING_DEGREE];
  nmq_result_t          result_q [$];

  // Schoolbook negacyclic product, each sum reduced into 0..q-1.
  function automatic void multiply_operands();
    longint acc [RING_DEGREE];
    longint term;
    longint v;
    for (int k = 0; k < RING_DEGREE; k++) acc[k] = 0;
    for (int i = 0; i < RING_DEGREE; i++) begin
      for (int j = 0; j < RING_DEGREE; j++) begin
        term = longint'(opnd_a[i]) * longint'(opnd_b[j]);
        if (i + j < RING_DEGREE) acc[i + j] += term;
        else acc[i + j - RING_DEGREE] -= term;
      end
    end
    for (int k = 0; k < RING_DEGREE; k++) begin
      v = acc[k] % MODQ;
      if (v < 0) v += MODQ;
      product[k] = CW'(v);
    end
  endfunction

  // Work out the result of one accepted item and update the stores.
  function automatic nmq_result_t predict_result(nmq_cmd_t cmd, int idx,
                                                  logic [CW-1:0] a,
                                                  logic signed [BW-1:0] b);
    nmq_result_t r;
    r.coef = '0;
    r.is_read = 1'b0;
    case (cmd)
      CMD_LOAD_A: if (idx < RING_DEGREE) opnd_a[idx] = a;
      CMD_LOAD_B: if (idx < RING_DEGREE) opnd_b[idx] = b;
      CMD_RUN:    multiply_operands();
      default: begin
        r.is_read = 1'b1;
        if (idx < RING_DEGREE) r.coef = product[idx];
      end
    endcase
    return r;
  endfunction

  initial begin
    err_count = 0;
    pending = 0;
    reads_checked = 0;
    for (int k = 0; k < RING_DEGREE; k++) begin
      opnd_a[k] = '0;
      opnd_b[k] = '0;
      product[k] = '0;
    end
  end

  // Predict on each accepted item, compare on each accepted result item.
  always @(posedge clk) begin
    nmq_result_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (in_valid && !in_stall)
        result_q.push_back(predict_result(nmq_cmd_t'(in_cmd), int'(in_index),
                                          in_coef_a, in_coef_b));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("Result item with no expectation waiting");
          errs++;
        end else begin
          want = result_q.pop_front();
          if (want.is_read) reads_checked <= reads_checked + 1;
          if (out_product_coef !== want.coef) begin
            $error("product_coef: expected %0d, got %0d", want.coef, out_product_coef);
            errs++;
          end
          if (out_is_read_data !== want.is_read) begin
            $error("is_read_data: expected %0d, got %0d", want.is_read,
                   out_is_read_data);
            errs++;
          end
        end
      end
      if (errs != 0) err_count <= err_count + errs;
      pending <= result_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the negacyclic multiplier mod 12289. Operands are filled,
// products formed and read back in three runs, with random idling on both
// channels, a long receiver hold-off and a pause for the block to drain.
// ----------------------------------------------------------------------------
module tb;
  import nmq_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_cmd;
  logic [IW-1:0]        in_index;
  logic [CW-1:0]        in_coef_a;
  logic signed [BW-1:0] in_coef_b;
  logic                 out_valid;
  logic                 out_stall;
  logic [CW-1:0]        out_product_coef;
  logic                 out_is_read_data;

  int err_count;
  int pending;
  int reads_checked;
  int items_sent;
  int runs_sent;
  int hold_reqs;
  int hold_served;
  int stall_left;
  bit quiet;

  negacyclic_poly_mul_mod_q dut (.*);

  nmq_checker u_checker (.*);

  // Clock and run limit.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stall bursts, long hold-offs on request.
  initial begin
    out_stall = 1'b0;
    hold_served = 0;
    stall_left = 0;
  end

  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_served + 1;
      stall_left <= 80;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item and hold it until it is taken.
  task automatic send_item(nmq_cmd_t cmd, int idx, logic [CW-1:0] a,
                           logic signed [BW-1:0] b);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_index  <= IW'(idx);
    in_coef_a <= a;
    in_coef_b <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_RUN) runs_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [CW-1:0] pick_a();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CW'(12288);
      2:       return '1;
      default: return CW'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic signed [BW-1:0] pick_b();
    case ($urandom_range(0, 7))
      0:       return -13'sd4096;
      1:       return 13'sd4095;
      2:       return '0;
      default: return BW'($urandom());
    endcase
  endfunction

  task automatic read_random(int n);
    for (int k = 0; k < n; k++)
      send_item(CMD_READ, $urandom_range(0, RING_DEGREE - 1), pick_a(), pick_b());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_READ;
    in_index = '0;
    in_coef_a = '0;
    in_coef_b = '0;
    hold_reqs = 0;
    quiet = 1'b0;
    items_sent = 0;
    runs_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Product reads zero before any run, at both ends of the index range.
    send_item(CMD_READ, 0, '0, '0);
    send_item(CMD_READ, RING_DEGREE - 1, '1, '1);

    // Fill both operands, then place extremes at the ends.
    for (int i = 0; i < RING_DEGREE; i++) begin
      send_item(CMD_LOAD_A, i, pick_a(), pick_b());
      send_item(CMD_LOAD_B, i, pick_a(), pick_b());
    end
    send_item(CMD_LOAD_A, 0, '0, '0);
    send_item(CMD_LOAD_A, 1, CW'(12288), '0);
    send_item(CMD_LOAD_A, RING_DEGREE - 1, '1, '0);
    send_item(CMD_LOAD_B, 0, '0, -13'sd4096);
    send_item(CMD_LOAD_B, 1, '0, '0);
    send_item(CMD_LOAD_B, RING_DEGREE - 1, '0, 13'sd4095);
    send_item(CMD_RUN, 0, '0, '0);
    send_item(CMD_READ, 0, '0, '0);
    send_item(CMD_READ, RING_DEGREE - 1, '0, '0);

    // Back the block up with a long receiver hold-off.
    hold_reqs <= hold_reqs + 1;
    read_random(200);

    // Mixed loads and reads; the old product stays readable.
    for (int k = 0; k < 200; k++) begin
      case ($urandom_range(0, 2))
        0: send_item(CMD_LOAD_A, $urandom_range(0, RING_DEGREE - 1), pick_a(), pick_b());
        1: send_item(CMD_LOAD_B, $urandom_range(0, RING_DEGREE - 1), pick_a(), pick_b());
        default: send_item(CMD_READ, $urandom_range(0, RING_DEGREE - 1), pick_a(), pick_b());
      endcase
    end
    send_item(CMD_RUN, $urandom_range(0, RING_DEGREE - 1), pick_a(), pick_b());
    read_random(200);

    // Sender waits for the block to drain, then loads extremes.
    drain_results();
    for (int k = 0; k < 60; k++) begin
      send_item(CMD_LOAD_A, $urandom_range(0, RING_DEGREE - 1),
                ($urandom_range(0, 1) != 0) ? CW'(12288) : CW'(16383), '0);
      send_item(CMD_LOAD_B, $urandom_range(0, RING_DEGREE - 1), '0,
                ($urandom_range(0, 1) != 0) ? -13'sd4096 : 13'sd4095);
    end
    send_item(CMD_RUN, 0, '0, '0);

    // Final stretch with no idling on either side.
    quiet = 1'b1;
    read_random(150);

    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d items including %0d runs; checked %0d product reads.",
             items_sent, runs_sent, reads_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[negacyclic_poly_mul_mod_q.f]
+incdir+hdl
hdl/nmq_pkg.sv
hdl/nmq_cell.sv
hdl/nmq_mac.sv
hdl/negacyclic_poly_mul_mod_q.sv
tb/nmq_checker.sv
tb/tb.sv
